[hw/rtl/isqrt_pkg.sv]
// Shared constants and types for the 64-bit integer square root pipeline.
package isqrt_pkg;

   // Radicand bits that take part in the root; bits above are ignored.
   localparam int RADICAND_WIDTH = 64;
   // Fixed widths of the transfer fields.
   localparam int RADICAND_BITS  = 64;
   localparam int ROOT_BITS      = 32;

   // One root bit is decided per step, two radicand bits are consumed per step.
   localparam int STEP_COUNT     = (RADICAND_WIDTH + 1) / 2;
   localparam int WORK_WIDTH     = 2 * STEP_COUNT;
   localparam int REM_WIDTH      = STEP_COUNT + 2;
   localparam int TRIAL_WIDTH    = STEP_COUNT + 1;

   // Contents of one pipeline stage.
   typedef struct packed {
      logic                   valid;
      logic [WORK_WIDTH-1:0]  work;
      logic [REM_WIDTH-1:0]   remainder;
      logic [TRIAL_WIDTH-1:0] trial;
   } isqrt_stage_type;

endpackage

[hw/rtl/isqrt_if.sv]
// Handshake interfaces for the radicand and root channels.
interface isqrt_req_if import isqrt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [RADICAND_BITS-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink (input valid, input radicand, output ready);
endinterface

interface isqrt_rsp_if import isqrt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROOT_BITS-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink (input valid, input root, output ready);
endinterface

[hw/rtl/isqrt_step.sv]
// One registered digit step of the restoring square root.
module isqrt_step import isqrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  isqrt_stage_type stage_in,
   output isqrt_stage_type stage_out
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [WORK_WIDTH-1:0]  work_ff;
   logic [WORK_WIDTH-1:0]  work_in;
   logic [REM_WIDTH-1:0]   remainder_ff;
   logic [REM_WIDTH-1:0]   remainder_in;
   logic [TRIAL_WIDTH-1:0] trial_ff;
   logic [TRIAL_WIDTH-1:0] trial_in;
   logic [REM_WIDTH-1:0]   rem_shift;
   logic [TRIAL_WIDTH-1:0] trial_shift;
   logic [REM_WIDTH-1:0]   trial_wide;

   always_comb begin
      // Bring in the next radicand pair; the top remainder bits are known to be zero.
      rem_shift   = {stage_in.remainder[REM_WIDTH-3:0], stage_in.work[WORK_WIDTH-1 -: 2]};
      trial_shift = stage_in.trial << 1;
      trial_wide  = REM_WIDTH'(trial_shift);
      valid_in    = stage_in.valid;
      work_in     = stage_in.work << 2;
      if (trial_wide < rem_shift) begin
         remainder_in = rem_shift - (trial_wide | REM_WIDTH'(1));
         trial_in     = trial_shift + TRIAL_WIDTH'(2);
      end else begin
         remainder_in = rem_shift;
         trial_in     = trial_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff      <= work_in;
         remainder_ff <= remainder_in;
         trial_ff     <= trial_in;
      end
   end

   assign stage_out = '{valid: valid_ff, work: work_ff, remainder: remainder_ff,
                        trial: trial_ff};

endmodule

[hw/rtl/integer_square_root_64.sv]
// Top level of the pipelined 64-bit integer square root unit.

// The unit returns floor(sqrt(radicand)) for each unsigned 64-bit radicand
// transfer, as a 32-bit root. It uses the binary digit-by-digit (restoring)
// method: each of the 32 pipeline stages takes in the next two radicand bits,
// most significant pair first, and decides one root bit by a trial
// subtraction from the running remainder. A new radicand may be transferred
// in every cycle while the result side keeps up; each item passes through
// the stages, one stage per root bit, and the final stage register is the output
// register. When the result side holds off, the whole pipeline freezes in
// place, so nothing is lost or repeated, and the input side is ready again as
// soon as the result waiting in the output register is taken. The unit keeps
// no state between items, and reset only clears the stage valid bits.
module integer_square_root_64 import isqrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   isqrt_req_if.sink   req_chan,
   isqrt_rsp_if.source rsp_chan
);

   isqrt_stage_type stage_link [0:STEP_COUNT];
   logic            advance;

   // The pipeline moves whenever the output register is empty or being emptied.
   assign advance        = !stage_link[STEP_COUNT].valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Only the low RADICAND_WIDTH bits are used; an odd width gains a leading zero.
   assign stage_link[0] = '{
      valid:     req_chan.valid,
      work:      WORK_WIDTH'(req_chan.radicand[RADICAND_WIDTH-1:0]),
      remainder: '0,
      trial:     '0
   };

   for (genvar g = 0; g < STEP_COUNT; g++) begin : g_step
      isqrt_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage_link[g]),
         .stage_out (stage_link[g+1])
      );
   end

   // The trial value holds twice the root.
   assign rsp_chan.valid = stage_link[STEP_COUNT].valid;
   assign rsp_chan.root  = ROOT_BITS'(stage_link[STEP_COUNT].trial[TRIAL_WIDTH-1:1]);

endmodule

[bench/tb_integer_square_root_64.sv]
// Self-checking testbench for the pipelined 64-bit integer square root unit.
module tb_integer_square_root_64 import isqrt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Count of random radicands sent after the directed table.
   localparam int RANDOM_RADICANDS = 800;
   // Cycles to keep watching the result side once nothing is outstanding.
   // This is the pipeline depth with some margin, so a stray extra root
   // would still be seen.
   localparam int DRAIN_CYCLES     = 2 * STEP_COUNT + 8;
   // Hard stop for the whole run in ns (400 us). The slowest correct run
   // sends 815 radicands, each behind a random sender gap, to a receiver
   // that may stall seven slots in eight; even so it ends well within
   // the limit.
   localparam int RUN_LIMIT_NS     = 400_000;
   localparam int DIRECTED_ROWS    = 15;

   // One row of the directed table. Where the root can be read off at a
   // glance it is typed in; otherwise the predictor supplies it.
   typedef struct packed {
      logic [RADICAND_BITS-1:0] radicand;
      logic                     root_known;
      logic [ROOT_BITS-1:0]     root;
   } root_case_type;

   // A radicand that has been transferred and whose root is still awaited.
   typedef struct packed {
      logic [RADICAND_BITS-1:0] radicand;
      logic [ROOT_BITS-1:0]     root;
   } pending_root_type;

   logic clock;
   logic reset;

   isqrt_req_if req_bus ();
   isqrt_rsp_if rsp_bus ();

   integer_square_root_64 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   pending_root_type pending_roots [$];
   int               error_count;
   int               burst_left;
   // While set, neither side idles, so the pipeline runs at full rate.
   logic             steady_phase;
   logic [7:0]       stall_pattern;
   logic [2:0]       stall_phase;

   // The directed table covers the extremes of the radicand: zero, the
   // smallest non-zero values, the all-ones value and its largest perfect
   // square, powers of four and their neighbours, and alternating patterns.
   root_case_type root_cases [DIRECTED_ROWS] = '{
      '{64'h0000_0000_0000_0000, 1'b1, 32'h0000_0000},
      '{64'h0000_0000_0000_0001, 1'b1, 32'h0000_0001},
      '{64'h0000_0000_0000_0002, 1'b1, 32'h0000_0001},
      '{64'h0000_0000_0000_0003, 1'b1, 32'h0000_0001},
      '{64'h0000_0000_0000_0004, 1'b1, 32'h0000_0002},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{64'hFFFF_FFFE_0000_0001, 1'b1, 32'hFFFF_FFFF},
      '{64'hFFFF_FFFE_0000_0000, 1'b1, 32'hFFFF_FFFE},
      '{64'h4000_0000_0000_0000, 1'b1, 32'h8000_0000},
      '{64'h3FFF_FFFF_FFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{64'h0000_0001_0000_0000, 1'b1, 32'h0001_0000},
      '{64'h0000_0000_FFFF_FFFF, 1'b1, 32'h0000_FFFF},
      '{64'h8000_0000_0000_0000, 1'b0, 32'h0000_0000},
      '{64'h5555_5555_5555_5555, 1'b0, 32'h0000_0000},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0000_0000}
   };

   // Free-running clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Floor of the square root, worked out by the restoring digit-by-digit
   // method: two radicand bits enter the remainder per step, and the trial
   // value, which holds twice the partial root, decides one root bit.
   function automatic logic [ROOT_BITS-1:0] floor_root(input logic [RADICAND_BITS-1:0] value);
      int unsigned width;
      int unsigned steps;
      logic [63:0] work;
      logic [63:0] remainder;
      logic [63:0] trial;
      width     = RADICAND_WIDTH;
      remainder = '0;
      trial     = '0;
      if (width < 2) begin
         width = 2;
      end
      if (width > 64) begin
         width = 64;
      end
      // Bits above the configured width take no part in the root.
      if (width < 64) begin
         value = value & ((64'd1 << width) - 64'd1);
      end
      // An odd width is padded with one leading zero to fill whole pairs.
      steps = (width + 1) / 2;
      work  = value << (64 - 2 * steps);
      for (int unsigned k = 0; k < steps; k++) begin
         trial     = trial << 1;
         remainder = (remainder << 2) | (work >> 62);
         work      = work << 2;
         if (trial < remainder) begin
            remainder = remainder - (trial | 64'd1);
            trial     = trial + 64'd2;
         end
      end
      return trial[ROOT_BITS:1];
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Sends one radicand and holds it until the unit takes it. The sender
   // works in bursts: valid stays high between transfers inside a burst,
   // and outside a steady phase it drops for a random gap between bursts.
   task automatic transfer_radicand(input logic [RADICAND_BITS-1:0] value,
                                    input logic root_known,
                                    input logic [ROOT_BITS-1:0] known_root);
      pending_root_type entry;
      if (burst_left == 0) begin
         if (!steady_phase) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid    <= 1'b1;
      req_bus.radicand <= value;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) begin
         @(posedge clock);
      end
      // The transfer has happened at this edge; the root it causes is
      // queued behind every root still in flight.
      entry.radicand = value;
      entry.root     = root_known ? known_root : floor_root(value);
      pending_roots.push_back(entry);
      burst_left--;
   endtask

   // Draws a radicand from one of several families, so that perfect squares
   // and their neighbours, short values and full-width values all turn up.
   function automatic logic [RADICAND_BITS-1:0] random_radicand();
      logic [RADICAND_BITS-1:0] full;
      logic [31:0]              base;
      full = {$urandom, $urandom};
      base = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return full;
         end
         3, 4, 5: begin
            // A perfect square, or one either side of it, which is where
            // the last trial subtraction is decided by a single unit.
            return 64'(base) * 64'(base) + 64'($urandom_range(0, 2)) - 64'd1;
         end
         6, 7: begin
            return full >> $urandom_range(0, 63);
         end
         8: begin
            return 64'($urandom_range(0, 1023));
         end
         default: begin
            // Values near the top of the range stress the widest remainder.
            return ~(full >> $urandom_range(8, 63));
         end
      endcase
   endfunction

   // The receiver stalls on an 8-bit pattern, redrawn whenever the phase
   // counter wraps. One slot of each pattern is always open, so the result
   // side never blocks for good; in a steady phase it never stalls at all.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 3'd1;
      if (stall_phase == 3'd7) begin
         stall_pattern <= 8'($urandom) | 8'h01;
      end
      rsp_bus.ready <= steady_phase || stall_pattern[stall_phase];
   end

   // Every root that is transferred out is compared with the oldest one
   // awaited. A root that arrives with nothing awaited is a failure too.
   always @(posedge clock) begin
      pending_root_type head;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_roots.size() == 0) begin
            report_mismatch($sformatf("unexpected root %h", rsp_bus.root));
         end else begin
            head = pending_roots.pop_front();
            if (rsp_bus.root !== head.root) begin
               report_mismatch($sformatf("radicand %h: root %h, predicted %h",
                                         head.radicand, rsp_bus.root, head.root));
            end
         end
      end
   end

   // Main sequence: reset, the directed table, the random radicands, then
   // the drain and the verdict.
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.radicand = '0;
      rsp_bus.ready    = 1'b0;
      stall_pattern    = 8'hFF;
      stall_phase      = 3'd0;
      steady_phase     = 1'b0;
      burst_left       = 0;
      error_count      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         transfer_radicand(root_cases[row].radicand, root_cases[row].root_known,
                           root_cases[row].root);
      end

      // Every fourth block of 50 radicands runs with no idling on either
      // side, so the pipeline is also seen full and streaming.
      for (int n = 0; n < RANDOM_RADICANDS; n++) begin
         steady_phase = ((n / 50) % 4) == 3;
         transfer_radicand(random_radicand(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
      steady_phase = 1'b0;

      // Wait for every outstanding root, then watch a while longer for
      // any root the unit should not have produced.
      while (pending_roots.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a run that has not ended by now has hung.
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d roots outstanding", pending_roots.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
